>>> design/fekc_pkg.sv
// ----------------------------------------------------------------------------
// fekc_pkg: shared types and constants of the FIFO-eviction key cache
// Sizes, item layouts and the control bundles passed between the sequencer,
// the age-order list and the key/value store.
// ----------------------------------------------------------------------------
package fekc_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int ECNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic signed [KEY_W-1:0]  key;
    logic        [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value_out;
    logic              evicted;
    logic [ECNT_W-1:0] entry_count;
  } out_item_t;

  // ins: push slot as newest, shifting positions 1..cnt down by one.
  // del: pull out position pos, close the gap below cnt, park slot at cnt-1.
  typedef struct packed {
    logic  ins;
    logic  del;
    slot_t pos;
    slot_t slot;
    cnt_t  cnt;
  } order_cmd_t;

  typedef struct packed {
    logic                   en;
    slot_t                  addr;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
  } store_wr_t;

endpackage

>>> design/fekc_order.sv
// ----------------------------------------------------------------------------
// fekc_order: age-order list of slot numbers, newest first
// Each position loads from itself, a fixed neighbor or the command's slot; one read port.
// ----------------------------------------------------------------------------
module fekc_order (
  input  logic                clk,
  input  logic                rst_n,
  input  fekc_pkg::order_cmd_t cmd,
  input  fekc_pkg::slot_t     rd_idx,
  output fekc_pkg::slot_t     rd_slot
);

  fekc_pkg::slot_t age_r   [fekc_pkg::DEPTH];
  fekc_pkg::slot_t age_nxt [fekc_pkg::DEPTH];

  assign rd_slot = age_r[rd_idx];

  for (genvar g = 0; g < fekc_pkg::DEPTH; g++) begin : g_pos
    localparam int DN = (g > 0) ? g - 1 : 0;
    localparam int UP = (g < fekc_pkg::DEPTH - 1) ? g + 1 : g;

    always_comb begin
      age_nxt[g] = age_r[g];
      if (cmd.ins) begin
        if (g == 0) begin
          age_nxt[g] = cmd.slot;
        end else if (g <= int'(cmd.cnt)) begin
          age_nxt[g] = age_r[DN];
        end
      end else if (cmd.del) begin
        if (g >= int'(cmd.pos) && g + 1 < int'(cmd.cnt)) begin
          age_nxt[g] = age_r[UP];
        end else if (g + 1 == int'(cmd.cnt)) begin
          age_nxt[g] = cmd.slot;
        end
      end
    end

    // Reset to the identity order: free slots are taken in ascending order.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        age_r[g] <= fekc_pkg::SLOT_W'(g);
      end else begin
        age_r[g] <= age_nxt[g];
      end
    end
  end

endmodule

>>> design/fekc_store.sv
// ----------------------------------------------------------------------------
// fekc_store: key and value memories indexed by slot
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fekc_store (
  input  logic                                clk,
  input  fekc_pkg::store_wr_t                 wr,
  input  fekc_pkg::slot_t                     rd_addr,
  output logic [fekc_pkg::KEY_W-1:0]          rd_key,
  output logic [fekc_pkg::VALUE_WIDTH-1:0]    rd_value
);

  logic [fekc_pkg::KEY_W-1:0]       key_mem [fekc_pkg::DEPTH];
  logic [fekc_pkg::VALUE_WIDTH-1:0] val_mem [fekc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= wr.key;
      val_mem[wr.addr] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_value <= val_mem[rd_addr];
  end

endmodule

>>> design/fifo_eviction_key_cache.sv
// ----------------------------------------------------------------------------
// fifo_eviction_key_cache: key/value cache with oldest-first eviction
// Sequencer around one key comparator, an age-order list and a slot store.
// ----------------------------------------------------------------------------
// Holds up to DEPTH key/value entries, newest first. Add stores a new
// entry as newest and, when the cache is at or above capacity, drops the
// oldest one and flags it as evicted. Get returns the value of the newest
// entry with a matching key; remove deletes that entry and closes the gap;
// flush empties the cache. Duplicate keys are kept. Capacity is to be written
// on the cfg port by the user only while the block is idle; the block itself
// does not enforce this. Capacity is used clamped to 1..DEPTH. One item is
// handled at a time. Get and remove scan the entries from the newest: one
// stored key is read from the key memory and compared per cycle, so they
// take longer the further back the match sits, and a miss scans every live
// entry. A finished result sits in the output register, and the next item
// can be accepted while it waits.
// ----------------------------------------------------------------------------
module fifo_eviction_key_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fekc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fekc_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fekc_pkg::CAP_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                       state_r, state_nxt;
  fekc_pkg::in_item_t           in_r, in_nxt;
  logic [fekc_pkg::CAP_W-1:0]   cap_r, cap_nxt;
  fekc_pkg::cnt_t               cnt_r, cnt_nxt;
  fekc_pkg::cnt_t               p_r, p_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  fekc_pkg::slot_t              rd_pos_r, rd_pos_nxt;
  fekc_pkg::slot_t              rd_slot_r, rd_slot_nxt;
  fekc_pkg::out_item_t          res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  fekc_pkg::out_item_t          out_data_r, out_data_nxt;

  fekc_pkg::order_cmd_t         ord_cmd;
  fekc_pkg::slot_t              ord_rd_idx;
  fekc_pkg::slot_t              ord_rd_slot;
  fekc_pkg::store_wr_t          st_wr;
  logic [fekc_pkg::KEY_W-1:0]       st_rd_key;
  logic [fekc_pkg::VALUE_WIDTH-1:0] st_rd_value;

  fekc_pkg::cnt_t               cap_eff;
  logic                         evict;
  fekc_pkg::cnt_t               cnt_ev;
  logic                         ins_ok;
  logic                         key_match;

  fekc_order u_order (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ord_cmd),
    .rd_idx  (ord_rd_idx),
    .rd_slot (ord_rd_slot)
  );

  // The store reads the slot named at the current age position; during an
  // add the same slot is the free one that gets written.
  fekc_store u_store (
    .clk      (clk),
    .wr       (st_wr),
    .rd_addr  (ord_rd_slot),
    .rd_key   (st_rd_key),
    .rd_value (st_rd_value)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp capacity to 1..DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = fekc_pkg::CNT_W'(1);
    end else if (int'(cap_r) > fekc_pkg::DEPTH) begin
      cap_eff = fekc_pkg::CNT_W'(fekc_pkg::DEPTH);
    end else begin
      cap_eff = fekc_pkg::CNT_W'(cap_r);
    end
  end

  // Evict only the single oldest entry, even if capacity was lowered.
  assign evict     = (cnt_r >= cap_eff) && (cnt_r != '0);
  assign cnt_ev    = cnt_r - fekc_pkg::CNT_W'(evict);
  assign ins_ok    = int'(cnt_ev) < fekc_pkg::DEPTH;
  assign key_match = rd_vld_r && (st_rd_key == in_r.key);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    cap_nxt       = cap_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    rd_vld_nxt    = 1'b0;
    rd_pos_nxt    = rd_pos_r;
    rd_slot_nxt   = rd_slot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    ord_cmd       = '0;
    ord_rd_idx    = fekc_pkg::SLOT_W'(p_r);
    st_wr         = '0;

    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          p_nxt  = '0;
          unique case (in_data.func)
            fekc_pkg::FUNC_ADD: begin
              state_nxt = S_ADD;
            end
            fekc_pkg::FUNC_REMOVE, fekc_pkg::FUNC_GET: begin
              state_nxt = S_SCAN;
            end
            fekc_pkg::FUNC_FLUSH: begin
              cnt_nxt   = '0;
              res_nxt   = '0;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_ADD: begin
        // Take the first free slot, push it as newest, write the entry.
        ord_rd_idx   = fekc_pkg::SLOT_W'(cnt_ev);
        ord_cmd.ins  = ins_ok;
        ord_cmd.cnt  = cnt_ev;
        ord_cmd.slot = ord_rd_slot;
        st_wr.en     = ins_ok;
        st_wr.addr   = ord_rd_slot;
        st_wr.key    = in_r.key;
        st_wr.value  = fekc_pkg::VALUE_WIDTH'(in_r.value);
        cnt_nxt      = cnt_ev + fekc_pkg::CNT_W'(ins_ok);
        res_nxt.hit         = 1'b0;
        res_nxt.value_out   = '0;
        res_nxt.evicted     = evict;
        res_nxt.entry_count = fekc_pkg::ECNT_W'(cnt_nxt);
        state_nxt    = S_RESP;
      end

      S_SCAN: begin
        // Compare the key read last cycle while the next one is fetched.
        priority if (key_match) begin
          res_nxt.hit     = 1'b1;
          res_nxt.evicted = 1'b0;
          if (in_r.func == fekc_pkg::FUNC_GET) begin
            res_nxt.value_out = fekc_pkg::DATA_W'(st_rd_value);
          end else begin
            res_nxt.value_out = '0;
            ord_cmd.del  = 1'b1;
            ord_cmd.pos  = rd_pos_r;
            ord_cmd.slot = rd_slot_r;
            ord_cmd.cnt  = cnt_r;
            cnt_nxt      = cnt_r - fekc_pkg::CNT_W'(1);
          end
          res_nxt.entry_count = fekc_pkg::ECNT_W'(cnt_nxt);
          state_nxt = S_RESP;
        end else if (!rd_vld_r && p_r >= cnt_r) begin
          res_nxt             = '0;
          res_nxt.entry_count = fekc_pkg::ECNT_W'(cnt_r);
          state_nxt           = S_RESP;
        end else if (p_r < cnt_r) begin
          rd_vld_nxt  = 1'b1;
          rd_pos_nxt  = fekc_pkg::SLOT_W'(p_r);
          rd_slot_nxt = ord_rd_slot;
          p_nxt       = p_r + fekc_pkg::CNT_W'(1);
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end

      S_RESP: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= fekc_pkg::CAP_RESET;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    p_r        <= p_nxt;
    rd_pos_r   <= rd_pos_nxt;
    rd_slot_r  <= rd_slot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= fekc_pkg::DEPTH)
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN) && (fekc_pkg::CNT_W'(rd_pos_r) < cnt_r))
    else $error("key read outside live entries");

  a_evict_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && res_r.evicted |-> in_r.func == fekc_pkg::FUNC_ADD)
    else $error("eviction reported for a non-add item");

  a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && res_r.hit |->
      (in_r.func == fekc_pkg::FUNC_GET) || (in_r.func == fekc_pkg::FUNC_REMOVE))
    else $error("hit reported for add or flush");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && key_match && (in_r.func == fekc_pkg::FUNC_REMOVE)
      |=> cnt_r == $past(cnt_r) - fekc_pkg::CNT_W'(1))
    else $error("remove hit did not drop one entry");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fifo_eviction_key_cache
// Drives add, remove, get and flush items through the valid/ready channels,
// predicts every result with a queue-based copy of the cache (newest entry
// first), and checks each result field by field under varying capacity
// settings and random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  // Abort when nothing moves on any channel for this many cycles.
  localparam int STALL_LIMIT = 4000;
  // Settle time after the last result, with margin over the longest scan.
  localparam int SETTLE_CYCLES = fekc_pkg::DEPTH + 8;
  localparam int SEGMENT_ITEMS = 260;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  fekc_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  fekc_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fekc_pkg::CAP_W-1:0]    cfg_data = '0;

  // Predicted cache contents, index 0 is the newest entry.
  logic [fekc_pkg::KEY_W-1:0]       cache_keys[$];
  logic [fekc_pkg::VALUE_WIDTH-1:0] cache_vals[$];
  logic [fekc_pkg::CAP_W-1:0]       capacity_reg = fekc_pkg::CAP_RESET;

  // Results predicted at acceptance and not yet seen on the output.
  fekc_pkg::out_item_t due_results[$];

  logic [fekc_pkg::KEY_W-1:0] key_pool[8];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int stall_cycles = 0;

  fifo_eviction_key_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one item to the predicted cache and return the result it causes.
  function automatic fekc_pkg::out_item_t cache_apply(input fekc_pkg::in_item_t item);
    fekc_pkg::out_item_t res;
    int unsigned cap_eff;
    int match;
    res = '0;
    cap_eff = (capacity_reg == 0) ? 1 :
              ((capacity_reg > fekc_pkg::DEPTH) ? fekc_pkg::DEPTH : capacity_reg);
    match = -1;
    for (int i = 0; i < cache_keys.size(); i++) begin
      if (match < 0 && cache_keys[i] == item.key) match = i;
    end
    case (item.func)
      fekc_pkg::FUNC_ADD: begin
        // Drop the oldest entry first when the cache is at (or over) capacity.
        if (cache_keys.size() >= cap_eff && cache_keys.size() > 0) begin
          void'(cache_keys.pop_back());
          void'(cache_vals.pop_back());
          res.evicted = 1'b1;
        end
        if (cache_keys.size() < fekc_pkg::DEPTH) begin
          cache_keys.push_front(item.key);
          cache_vals.push_front(item.value[fekc_pkg::VALUE_WIDTH-1:0]);
        end
      end
      fekc_pkg::FUNC_REMOVE: begin
        if (match >= 0) begin
          cache_keys.delete(match);
          cache_vals.delete(match);
          res.hit = 1'b1;
        end
      end
      fekc_pkg::FUNC_GET: begin
        if (match >= 0) begin
          res.hit = 1'b1;
          res.value_out = fekc_pkg::DATA_W'(cache_vals[match]);
        end
      end
      default: begin
        cache_keys.delete();
        cache_vals.delete();
      end
    endcase
    res.entry_count = fekc_pkg::ECNT_W'(cache_keys.size());
    return res;
  endfunction

  // Present one item, idling first at the sender's rate; return at the
  // edge that accepts it, leaving valid high for a possible next item.
  task automatic send_item(input fekc_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(cache_apply(item));
  endtask

  task automatic send_op(input fekc_pkg::func_t func,
                         input logic [fekc_pkg::KEY_W-1:0] key,
                         input logic [fekc_pkg::DATA_W-1:0] value);
    fekc_pkg::in_item_t item;
    item.func  = func;
    item.key   = key;
    item.value = value;
    send_item(item);
  endtask

  // Hold the input idle until every predicted result has come back,
  // then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register only once the block is idle.
  task automatic write_capacity(input logic [fekc_pkg::CAP_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
  endtask

  function automatic logic [fekc_pkg::KEY_W-1:0] pick_key_extreme();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Refill the small key set that most random items draw from, so that
  // gets and removes find entries often.
  task automatic refill_key_pool();
    foreach (key_pool[i]) key_pool[i] = ($urandom_range(3) == 0) ? pick_key_extreme() : $urandom;
  endtask

  function automatic fekc_pkg::in_item_t random_item();
    fekc_pkg::in_item_t item;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) item.func = fekc_pkg::FUNC_ADD;
    else if (sel < 72) item.func = fekc_pkg::FUNC_GET;
    else if (sel < 97) item.func = fekc_pkg::FUNC_REMOVE;
    else item.func = fekc_pkg::FUNC_FLUSH;
    item.key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom;
    item.value = $urandom;
    return item;
  endfunction

  // Operations at the reset capacity: misses on an empty cache, duplicate
  // keys, removal of the newest duplicate, flush.
  task automatic test_basic_ops();
    send_op(fekc_pkg::FUNC_GET,    32'h0000_0000, 32'hdead_beef);
    send_op(fekc_pkg::FUNC_REMOVE, 32'hffff_ffff, 32'h0000_0001);
    send_op(fekc_pkg::FUNC_ADD,    32'h7fff_ffff, 32'hffff_ffff);
    send_op(fekc_pkg::FUNC_ADD,    32'h8000_0000, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_ADD,    32'h8000_0000, 32'h1234_5678);
    send_op(fekc_pkg::FUNC_GET,    32'h8000_0000, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_REMOVE, 32'h8000_0000, 32'hffff_ffff);
    send_op(fekc_pkg::FUNC_GET,    32'h8000_0000, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_GET,    32'h7fff_ffff, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_FLUSH,  32'h7fff_ffff, 32'hffff_ffff);
  endtask

  // Capacity clamping and eviction: zero acts as one, a value above DEPTH
  // acts as DEPTH, and lowering capacity below the count keeps the count.
  task automatic test_capacity_clamp();
    write_capacity(5'd0);
    send_op(fekc_pkg::FUNC_ADD, 32'h0000_0011, 32'haaaa_aaaa);
    send_op(fekc_pkg::FUNC_ADD, 32'h0000_0022, 32'h5555_5555);
    send_op(fekc_pkg::FUNC_GET, 32'h0000_0011, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_GET, 32'h0000_0022, 32'h0000_0000);
    write_capacity(5'd31);
    send_op(fekc_pkg::FUNC_ADD, 32'h0000_0033, 32'h0000_0003);
    send_op(fekc_pkg::FUNC_ADD, 32'hffff_ffff, 32'h8000_0000);
    send_op(fekc_pkg::FUNC_ADD, 32'h0000_0044, 32'h0000_0004);
    write_capacity(5'd2);
    send_op(fekc_pkg::FUNC_ADD, 32'h0000_0055, 32'h0000_0005);
    send_op(fekc_pkg::FUNC_GET, 32'h0000_0022, 32'h0000_0000);
    send_op(fekc_pkg::FUNC_FLUSH, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Random traffic in segments: each segment picks a capacity and an
  // idling mode, and draws most keys from a fresh small pool.
  task automatic test_random_traffic();
    logic [fekc_pkg::CAP_W-1:0] seg_cap[6];
    seg_cap[0] = 5'd16;
    seg_cap[1] = 5'd1;
    seg_cap[2] = 5'd31;
    seg_cap[3] = fekc_pkg::CAP_W'($urandom_range(2, 15));
    seg_cap[4] = 5'd0;
    seg_cap[5] = fekc_pkg::CAP_W'($urandom_range(31));
    for (int seg = 0; seg < 6; seg++) begin
      write_capacity(seg_cap[seg]);
      if (seg < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 61;
      end else if (seg < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      refill_key_pool();
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_item(random_item());
    end
  endtask

  // Result side: stall at the receiver's rate and check each accepted item
  // against the oldest prediction.
  always @(posedge clk) begin
    fekc_pkg::out_item_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result item with no prediction waiting");
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          error_count++;
        end
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_data.value_out);
          error_count++;
        end
        if (out_data.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, out_data.evicted);
          error_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_capacity_clamp();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
